// ===== rtl/calu_pkg.sv =====
// Package with the command codes and flag type shared by the ALU files.
package calu_pkg;

	localparam int unsigned CmdW  = 5;
	localparam int unsigned WordW = 16;
	localparam int unsigned ByteW = 8;
	localparam int unsigned IdxW  = 3;

	localparam logic [CmdW-1:0] CMD_ADD      = 5'd0;
	localparam logic [CmdW-1:0] CMD_ADC      = 5'd1;
	localparam logic [CmdW-1:0] CMD_SUB      = 5'd2;
	localparam logic [CmdW-1:0] CMD_CP       = 5'd3;
	localparam logic [CmdW-1:0] CMD_AND      = 5'd4;
	localparam logic [CmdW-1:0] CMD_OR       = 5'd5;
	localparam logic [CmdW-1:0] CMD_XOR      = 5'd6;
	localparam logic [CmdW-1:0] CMD_INC      = 5'd7;
	localparam logic [CmdW-1:0] CMD_DEC      = 5'd8;
	localparam logic [CmdW-1:0] CMD_RL       = 5'd9;
	localparam logic [CmdW-1:0] CMD_RLA      = 5'd10;
	localparam logic [CmdW-1:0] CMD_RR       = 5'd11;
	localparam logic [CmdW-1:0] CMD_RRA      = 5'd12;
	localparam logic [CmdW-1:0] CMD_SRL      = 5'd13;
	localparam logic [CmdW-1:0] CMD_SWAP     = 5'd14;
	localparam logic [CmdW-1:0] CMD_BIT      = 5'd15;
	localparam logic [CmdW-1:0] CMD_CPL      = 5'd16;
	localparam logic [CmdW-1:0] CMD_ADD_WORD = 5'd17;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} calu_flags_t;

	localparam calu_flags_t FLAGS_CLEAR = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

// ===== rtl/calu_ifs.sv =====
// Valid/ready channel interfaces for the ALU request and result streams.
interface calu_in_if import calu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CmdW-1:0]    cmd;
	logic [WordW-1:0]   operand_a;
	logic [WordW-1:0]   operand_b;
	logic [IdxW-1:0]    bit_index;

	modport source (output valid, cmd, operand_a, operand_b, bit_index, input ready);
	modport sink (input valid, cmd, operand_a, operand_b, bit_index, output ready);
endinterface

interface calu_out_if import calu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WordW-1:0]   result;
	logic               zero_flag;
	logic               subtract_flag;
	logic               half_carry_flag;
	logic               carry_flag;

	modport source (output valid, result, zero_flag, subtract_flag, half_carry_flag,
		carry_flag, input ready);
	modport sink (input valid, result, zero_flag, subtract_flag, half_carry_flag,
		carry_flag, output ready);
endinterface

// ===== rtl/calu_core.sv =====
// Combinational datapath: one operation on the operands and the current flags.
module calu_core import calu_pkg::*; (
	input  logic [CmdW-1:0]  cmd,
	input  logic [WordW-1:0] operand_a,
	input  logic [WordW-1:0] operand_b,
	input  logic [IdxW-1:0]  bit_index,
	input  calu_flags_t      flags_in,
	output logic [WordW-1:0] result,
	output calu_flags_t      flags_out
);

	logic [ByteW-1:0] a;
	logic [ByteW-1:0] b;
	logic             cin;
	logic [ByteW:0]   sum9;
	logic [4:0]       half_sum;
	logic [ByteW:0]   diff9;
	logic [WordW:0]   word_sum;
	logic [12:0]      word_half;
	logic [ByteW-1:0] r8;

	assign a = operand_a[ByteW-1:0];
	assign b = operand_b[ByteW-1:0];

	// Carry in only for ADC; ADD ignores the stored carry.
	assign cin       = (cmd == CMD_ADC) ? flags_in.c : 1'b0;
	assign sum9      = {1'b0, a} + {1'b0, b} + {8'd0, cin};
	assign half_sum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
	assign diff9     = {1'b0, a} - {1'b0, b};
	assign word_sum  = {1'b0, operand_a} + {1'b0, operand_b};
	assign word_half = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

	always_comb begin
		result    = operand_a;
		flags_out = flags_in;
		r8        = '0;
		case (cmd)
			CMD_ADD, CMD_ADC: begin
				r8        = sum9[ByteW-1:0];
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b0, h: half_sum[4], c: sum9[ByteW]};
			end
			CMD_SUB, CMD_CP: begin
				r8        = diff9[ByteW-1:0];
				result    = (cmd == CMD_SUB) ? {8'd0, r8} : operand_a;
				flags_out = '{z: (r8 == '0), n: 1'b1, h: (a[3:0] < b[3:0]), c: diff9[ByteW]};
			end
			CMD_AND: begin
				r8        = a & b;
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			CMD_OR, CMD_XOR: begin
				r8        = (cmd == CMD_OR) ? (a | b) : (a ^ b);
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_INC: begin
				r8        = a + 8'd1;
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b0, h: (r8[3:0] == 4'h0), c: flags_in.c};
			end
			CMD_DEC: begin
				r8        = a - 8'd1;
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b1, h: (r8[3:0] == 4'hF), c: flags_in.c};
			end
			CMD_RL, CMD_RLA: begin
				r8        = {a[6:0], flags_in.c};
				result    = {8'd0, r8};
				flags_out = '{z: (cmd == CMD_RL) && (r8 == '0), n: 1'b0, h: 1'b0, c: a[7]};
			end
			CMD_RR, CMD_RRA: begin
				r8        = {flags_in.c, a[7:1]};
				result    = {8'd0, r8};
				flags_out = '{z: (cmd == CMD_RR) && (r8 == '0), n: 1'b0, h: 1'b0, c: a[0]};
			end
			CMD_SRL: begin
				r8        = {1'b0, a[7:1]};
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[0]};
			end
			CMD_SWAP: begin
				r8        = {a[3:0], a[7:4]};
				result    = {8'd0, r8};
				flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_BIT: begin
				flags_out = '{z: !a[bit_index], n: 1'b0, h: 1'b1, c: flags_in.c};
			end
			CMD_CPL: begin
				r8          = ~a;
				result      = {8'd0, r8};
				flags_out.n = 1'b1;
				flags_out.h = 1'b1;
			end
			CMD_ADD_WORD: begin
				result    = word_sum[WordW-1:0];
				flags_out = '{z: flags_in.z, n: 1'b0, h: word_half[12], c: word_sum[WordW]};
			end
			default: begin
				result    = operand_a;
				flags_out = flags_in;
			end
		endcase
	end

endmodule

// ===== rtl/cpu_alu_with_flags.sv =====
// Top level of the eight-bit ALU with its kept Z/N/H/C flag register.
// A request is held in the input register and then in the result register, which offers its result.
// One request per cycle while the result is not stalled; the flag register feeds the next request directly.
// A stalled result holds the output register while one more request waits in the input register.
// Reset (arst_n low, asynchronous) empties both registers and clears all four flags.
module cpu_alu_with_flags import calu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	calu_in_if.sink    din,
	calu_out_if.source dout
);

	// Input register: the request being worked on this cycle.
	logic             valid_s1;
	logic [CmdW-1:0]  cmd_s1;
	logic [WordW-1:0] opa_s1;
	logic [WordW-1:0] opb_s1;
	logic [IdxW-1:0]  idx_s1;

	// Result register. The flag register doubles as the flag part of the result,
	// since it is loaded at the same edge as the result value.
	logic             valid_s2;
	logic [WordW-1:0] res_s2;
	calu_flags_t      flags_q;

	logic [WordW-1:0] core_result;
	calu_flags_t      core_flags;
	logic             advance;

	// The input register moves on when the result register is empty or being drained.
	assign advance   = !valid_s2 || dout.ready;
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	// Payload needs no reset; it is only looked at when valid_s1 is set.
	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			cmd_s1 <= din.cmd;
			opa_s1 <= din.operand_a;
			opb_s1 <= din.operand_b;
			idx_s1 <= din.bit_index;
		end
	end

	calu_core u_core (
		.cmd       (cmd_s1),
		.operand_a (opa_s1),
		.operand_b (opb_s1),
		.bit_index (idx_s1),
		.flags_in  (flags_q),
		.result    (core_result),
		.flags_out (core_flags)
	);

	// Flags commit exactly when a request leaves the input register, so the next
	// request in line always sees the flags left by its predecessor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_q  <= FLAGS_CLEAR;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				flags_q <= core_flags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= core_result;
		end
	end

	assign dout.valid           = valid_s2;
	assign dout.result          = res_s2;
	assign dout.zero_flag       = flags_q.z;
	assign dout.subtract_flag   = flags_q.n;
	assign dout.half_carry_flag = flags_q.h;
	assign dout.carry_flag      = flags_q.c;

	// A stalled result must keep its flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !dout.ready |=> $stable(flags_q))
		else $error("flags changed while the result was stalled");

	// A request held behind a stalled result is neither lost nor altered.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !dout.ready |=> valid_s1 && $stable(opa_s1) && $stable(cmd_s1))
		else $error("waiting request lost or altered during a stall");

	// An accepted request is in the input register at the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> valid_s1)
		else $error("accepted request did not reach the input register");

	// A worked request always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("worked request did not reach the result register");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the eight-bit ALU with its kept Z/N/H/C flag register.
module testbench;
	import calu_pkg::*;

	// Command codes that the block does not decode; it must pass operand_a through and keep
	// every flag for these.
	localparam logic [CmdW-1:0] CMD_UNUSED_LO = 5'd18;
	localparam logic [CmdW-1:0] CMD_UNUSED_HI = 5'd31;

	localparam int unsigned RandomReqs = 950;

	// One request as it is presented on the input channel.
	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [WordW-1:0] operand_a;
		logic [WordW-1:0] operand_b;
		logic [IdxW-1:0]  bit_index;
	} alu_req_t;

	// The value written back together with the whole flag register after the operation.
	typedef struct packed {
		logic [WordW-1:0] result;
		calu_flags_t      flags;
	} alu_res_t;

	// Stall patterns of the result side; each holds for a stretch of cycles.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b1;
	logic arst_n;

	calu_in_if  req_ch ();
	calu_out_if res_ch ();

	cpu_alu_with_flags u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (req_ch),
		.dout   (res_ch)
	);

	// Requests still to be offered, and the results that accepted requests must produce, in
	// the order in which the requests were accepted.
	alu_req_t    pending_reqs[$];
	alu_res_t    results_due[$];

	// The flag register as the block should hold it after every accepted request.
	calu_flags_t flag_state = FLAGS_CLEAR;

	int unsigned fail_count = 0;
	logic        req_taken  = 1'b0;
	int          burst_left;
	int          gap_left   = 0;
	int unsigned rx_cycle   = 0;
	rx_mode_t    rx_mode    = RX_OPEN;

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Works out the value written back and the new flags for one request, starting from the
	// flags left behind by the previous request. Byte operations see only the low eight bits
	// of each operand and give a zero-extended byte.
	function automatic alu_res_t alu_outcome(alu_req_t req, calu_flags_t prev);
		alu_res_t         res;
		logic [ByteW-1:0] a;
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] r;
		logic [ByteW:0]   sum9;
		logic [4:0]       nib_sum;
		logic [WordW:0]   sum17;
		logic [12:0]      sum13;
		logic             cin;

		a          = req.operand_a[ByteW-1:0];
		b          = req.operand_b[ByteW-1:0];
		cin        = prev.c;
		res.flags  = prev;
		res.result = req.operand_a;
		r          = '0;

		case (req.cmd)
			CMD_ADD, CMD_ADC: begin
				if (req.cmd == CMD_ADD) begin
					cin = 1'b0;
				end
				sum9      = {1'b0, a} + {1'b0, b} + {8'd0, cin};
				nib_sum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
				r         = sum9[ByteW-1:0];
				res.flags = '{z: (r == '0), n: 1'b0, h: nib_sum[4], c: sum9[ByteW]};
				res.result = {8'h00, r};
			end
			CMD_SUB, CMD_CP: begin
				r         = a - b;
				res.flags = '{z: (r == '0), n: 1'b1, h: (a[3:0] < b[3:0]), c: (a < b)};
				// A compare only sets flags: operand_a comes back whole.
				if (req.cmd == CMD_SUB) begin
					res.result = {8'h00, r};
				end
			end
			CMD_AND: begin
				r          = a & b;
				res.flags  = '{z: (r == '0), n: 1'b0, h: 1'b1, c: 1'b0};
				res.result = {8'h00, r};
			end
			CMD_OR, CMD_XOR: begin
				r          = (req.cmd == CMD_OR) ? (a | b) : (a ^ b);
				res.flags  = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
				res.result = {8'h00, r};
			end
			CMD_INC: begin
				r          = a + 8'd1;
				res.flags  = '{z: (r == '0), n: 1'b0, h: (r[3:0] == 4'h0), c: prev.c};
				res.result = {8'h00, r};
			end
			CMD_DEC: begin
				r          = a - 8'd1;
				res.flags  = '{z: (r == '0), n: 1'b1, h: (r[3:0] == 4'hF), c: prev.c};
				res.result = {8'h00, r};
			end
			CMD_RL, CMD_RLA: begin
				r          = {a[6:0], cin};
				res.flags  = '{z: (req.cmd == CMD_RL) && (r == '0), n: 1'b0, h: 1'b0, c: a[7]};
				res.result = {8'h00, r};
			end
			CMD_RR, CMD_RRA: begin
				r          = {cin, a[7:1]};
				res.flags  = '{z: (req.cmd == CMD_RR) && (r == '0), n: 1'b0, h: 1'b0, c: a[0]};
				res.result = {8'h00, r};
			end
			CMD_SRL: begin
				r          = {1'b0, a[7:1]};
				res.flags  = '{z: (r == '0), n: 1'b0, h: 1'b0, c: a[0]};
				res.result = {8'h00, r};
			end
			CMD_SWAP: begin
				r          = {a[3:0], a[7:4]};
				res.flags  = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
				res.result = {8'h00, r};
			end
			CMD_BIT: begin
				res.flags = '{z: !a[req.bit_index], n: 1'b0, h: 1'b1, c: prev.c};
			end
			CMD_CPL: begin
				r          = ~a;
				res.flags  = '{z: prev.z, n: 1'b1, h: 1'b1, c: prev.c};
				res.result = {8'h00, r};
			end
			CMD_ADD_WORD: begin
				sum17      = {1'b0, req.operand_a} + {1'b0, req.operand_b};
				sum13      = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
				res.flags  = '{z: prev.z, n: 1'b0, h: sum13[12], c: sum17[WordW]};
				res.result = sum17[WordW-1:0];
			end
			default: begin
				// Undecoded command: operand_a passes through and the flags stay as they were.
			end
		endcase
		return res;
	endfunction

	task automatic add_req(logic [CmdW-1:0] cmd, logic [WordW-1:0] opa,
		logic [WordW-1:0] opb, logic [IdxW-1:0] idx);
		pending_reqs.push_back('{cmd: cmd, operand_a: opa, operand_b: opb, bit_index: idx});
	endtask

	// Operands lean towards the byte and word edges where carries and half carries change,
	// with random upper bits so that the block is seen to ignore them on byte operations.
	function automatic logic [WordW-1:0] pick_operand();
		logic [WordW-1:0] v;

		v = WordW'($urandom);
		case ($urandom_range(0, 9))
			0: v[7:0] = 8'h00;
			1: v[7:0] = 8'hFF;
			2: v[7:0] = 8'h0F;
			3: v[7:0] = 8'hF0;
			4: v[7:0] = 8'h80;
			5: v[7:0] = 8'h01;
			6: v = 16'hFFFF;
			7: v[11:0] = 12'hFFF;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [CmdW-1:0] pick_cmd();
		if ($urandom_range(0, 19) == 0) begin
			return CmdW'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		return CmdW'($urandom_range(CMD_ADD, CMD_ADD_WORD));
	endfunction

	task automatic report_field(string fname, logic [WordW-1:0] want, logic [WordW-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// Request side. Requests go out in bursts of random length separated by random gaps; a
	// request on the channel is held until it has been taken. The driver works at the falling
	// edge so that everything it changes is settled by the next rising edge.
	initial burst_left = $urandom_range(1, 24);

	always @(negedge clk) begin
		alu_req_t nxt;

		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				nxt = pending_reqs.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.cmd       <= nxt.cmd;
				req_ch.operand_a <= nxt.operand_a;
				req_ch.operand_b <= nxt.operand_b;
				req_ch.bit_index <= nxt.bit_index;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					// About a third of the bursts run straight on into the next one.
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result side. The ready pattern switches among always ready, lightly stalled, heavily
	// stalled and a fixed periodic pattern, so that stalls land on every phase of the request
	// bursts and there are long stretches with no stalls at all.
	always @(negedge clk) begin
		logic rdy;

		rx_cycle++;
		if (rx_cycle % 96 == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		end
		case (rx_mode)
			RX_OPEN:     rdy = 1'b1;
			RX_LIGHT:    rdy = ($urandom_range(0, 3) != 0);
			RX_HEAVY:    rdy = ($urandom_range(0, 3) == 0);
			default:     rdy = ((rx_cycle % 7) < 2);
		endcase
		res_ch.ready <= rdy;
	end

	// Monitor. At each rising edge an accepted request is run through the predictor, which
	// also advances the predicted flag register, and an accepted result is checked against
	// the oldest outstanding prediction. Requests and results both leave in order, so a
	// simple FIFO of predictions is enough.
	always @(posedge clk) begin
		alu_req_t taken;
		alu_res_t due;

		req_taken <= arst_n && req_ch.valid && req_ch.ready;

		if (arst_n && req_ch.valid && req_ch.ready) begin
			taken = '{cmd: req_ch.cmd, operand_a: req_ch.operand_a,
				operand_b: req_ch.operand_b, bit_index: req_ch.bit_index};
			due        = alu_outcome(taken, flag_state);
			flag_state = due.flags;
			results_due.push_back(due);
		end

		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: result with no request outstanding, actual %h", $time,
					res_ch.result);
				fail_count++;
			end else begin
				due = results_due.pop_front();
				report_field("result", due.result, res_ch.result);
				report_field("zero_flag", WordW'(due.flags.z), WordW'(res_ch.zero_flag));
				report_field("subtract_flag", WordW'(due.flags.n),
					WordW'(res_ch.subtract_flag));
				report_field("half_carry_flag", WordW'(due.flags.h),
					WordW'(res_ch.half_carry_flag));
				report_field("carry_flag", WordW'(due.flags.c), WordW'(res_ch.carry_flag));
			end
		end
	end

	// Stimulus, reset and the end of the run.
	initial begin
		int unsigned n;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = '0;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		req_ch.bit_index = '0;
		res_ch.ready     = 1'b0;

		// Directed requests. The flags carry from one request to the next, so the order
		// matters: the carry set by the first add feeds the add with carry after it.
		add_req(CMD_ADD,      16'hA5FF, 16'h5A01, 3'd0); // zero, half carry and carry at once
		add_req(CMD_ADC,      16'h000F, 16'h0000, 3'd0); // carry in makes a half carry
		add_req(CMD_ADC,      16'hFF7F, 16'hFF80, 3'd0); // no carry in this time
		add_req(CMD_SUB,      16'h1234, 16'h4334, 3'd0); // equal low bytes give zero
		add_req(CMD_SUB,      16'h0010, 16'h0001, 3'd0); // borrow from bit 4 only
		add_req(CMD_CP,       16'hBE00, 16'h00FF, 3'd0); // operand_a comes back with all bits
		add_req(CMD_AND,      16'hFFF0, 16'hFF0F, 3'd0); // disjoint bits give zero
		add_req(CMD_OR,       16'h0000, 16'h0000, 3'd0);
		add_req(CMD_XOR,      16'h00C3, 16'h003C, 3'd0);
		add_req(CMD_INC,      16'h00FF, 16'h0000, 3'd0); // wraps to zero, carry kept
		add_req(CMD_DEC,      16'h0010, 16'h0000, 3'd0); // low nibble wraps downwards
		add_req(CMD_DEC,      16'h0001, 16'h0000, 3'd0);
		add_req(CMD_RL,       16'h0080, 16'h0000, 3'd0); // bit 7 out to carry, zero as no carry comes in
		add_req(CMD_RLA,      16'h0080, 16'h0000, 3'd0); // the accumulator form never sets zero
		add_req(CMD_RR,       16'h0001, 16'h0000, 3'd0);
		add_req(CMD_RRA,      16'h0001, 16'h0000, 3'd0);
		add_req(CMD_SRL,      16'hFF01, 16'h0000, 3'd0);
		add_req(CMD_SWAP,     16'h00F0, 16'h0000, 3'd0);
		add_req(CMD_BIT,      16'hAB7F, 16'h0000, 3'd7); // tested bit clear sets zero
		add_req(CMD_BIT,      16'h0001, 16'h0000, 3'd0);
		add_req(CMD_CPL,      16'hFF5A, 16'h0000, 3'd0); // zero and carry kept
		add_req(CMD_ADD_WORD, 16'hFFFF, 16'h0001, 3'd0); // wraps to zero, zero flag kept
		add_req(CMD_ADD_WORD, 16'h0FFF, 16'h0001, 3'd0); // half carry out of bit 11
		add_req(CMD_UNUSED_LO, 16'hDEAD, 16'hBEEF, 3'd5);
		add_req(CMD_UNUSED_HI, 16'h1234, 16'hFFFF, 3'd7);

		for (n = 0; n < RandomReqs; n++) begin
			add_req(pick_cmd(), pick_operand(), pick_operand(), IdxW'($urandom));
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken and every result to arrive, then a few cycles
		// more so that any stray result would still be seen.
		while (pending_reqs.size() != 0 || req_ch.valid || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: the slowest correct run takes a small fraction of this.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
